// ===== rtl/core/umb_pkg.sv =====
package umb_pkg;

   localparam int CHANNELS      = 3;
   localparam int PIX_W         = 8;
   localparam int MAX_WIDTH_DEF = 1024;

   localparam int FW_W          = 11;
   localparam int FH_W          = 12;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;

   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 12;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // nine 8-bit taps at most, 9 * 255 fits in 12 bits
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 16;

   typedef struct packed {
      logic accept;
      logic shift;
      logic sum;
      logic mul;
      logic load;
      logic csr_write;
   } umb_cmd_type;

   typedef struct packed {
      logic result_due;
      logic out_free;
   } umb_status_type;

   // ceil(2^16 / count); exact floor division for any sum below 2^12
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd6:    r = 17'd10923;
         4'd9:    r = 17'd7282;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/unsharp_mask_box3x3.sv =====
// channel  dir  handshake           payload
// req      in   req_valid/req_stall  req_command, req_red_in, req_green_in, req_blue_in
// rsp      out  rsp_valid/rsp_stall  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end
// csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
// a transaction with a result is walked by the controller through line-memory read,
// window shift, masked sum, reciprocal multiply and the sharpen/output stage; one with
// no result ends after the window shift, and a stalled output register holds the last stage.
// reset is synchronous; line memories are undefined until written, no clearing pass.
// rsp_stall holds the output register; the next req transaction is taken meanwhile, but its result waits.
module unsharp_mask_box3x3 #(
   parameter int MAX_WIDTH = umb_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [umb_pkg::PIX_W-1:0]      req_red_in,
   input  logic [umb_pkg::PIX_W-1:0]      req_green_in,
   input  logic [umb_pkg::PIX_W-1:0]      req_blue_in,
   // sharpened output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [umb_pkg::PIX_W-1:0]      rsp_red_out,
   output logic [umb_pkg::PIX_W-1:0]      rsp_green_out,
   output logic [umb_pkg::PIX_W-1:0]      rsp_blue_out,
   output logic                          rsp_frame_end,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [umb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [umb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import umb_pkg::*;

   // command and status between sequencer and datapath
   umb_cmd_type    cmd;
   umb_status_type status;

   // sequencer: one transaction at a time, register writes only when idle
   umb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line memories, 3x3 window, frame counters, divide by reciprocal, output register
   umb_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_command   (req_command),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   // an accepted transaction always shifts the window in the next cycle
   a_accept_then_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.shift)
      else $error("accepted transaction was not shifted into the window");

   // a result is never loaded over one that is still held by the consumer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || !rsp_stall))
      else $error("output register overwritten while stalled");

   // register writes and pixel transactions never land in the same cycle
   a_csr_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.csr_write && cmd.accept))
      else $error("register write collided with a transaction");

endmodule

// ===== rtl/core/umb_ctrl.sv =====
module umb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  umb_pkg::umb_status_type status,
   output umb_pkg::umb_cmd_type    cmd
);
   import umb_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign csr_ready = (state_ff == ST_IDLE);
   // register writes win over a waiting transaction
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.csr_write = csr_valid;
            cmd.accept    = req_valid && !csr_valid;
            if (cmd.accept) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = status.result_due ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/umb_datapath.sv =====
module umb_datapath #(
   parameter int MAX_WIDTH = umb_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  umb_pkg::umb_cmd_type               cmd,
   output umb_pkg::umb_status_type            status,
   input  logic                              req_command,
   input  logic [umb_pkg::PIX_W-1:0]          req_red_in,
   input  logic [umb_pkg::PIX_W-1:0]          req_green_in,
   input  logic [umb_pkg::PIX_W-1:0]          req_blue_in,
   input  logic [umb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [umb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [umb_pkg::PIX_W-1:0]          rsp_red_out,
   output logic [umb_pkg::PIX_W-1:0]          rsp_green_out,
   output logic [umb_pkg::PIX_W-1:0]          rsp_blue_out,
   output logic                              rsp_frame_end
);
   import umb_pkg::*;

   localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int TW      = $clog2(MAX_WIDTH * 4096 + 1);
   localparam int NW      = WW + FH_W;
   localparam int PXW     = CHANNELS * PIX_W;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int W_RST   = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam int NPIX_RST = W_RST * HEIGHT_RESET;

   typedef logic [CHANNELS-1:0][PIX_W-1:0] pix_type;

   // configuration
   logic [FW_W-1:0] width_ff, width_in;
   logic [FH_W-1:0] height_ff, height_in;
   logic            restart;
   logic [WW-1:0]   weff_ff, weff_in;
   logic [FH_W-1:0] heff_ff, heff_in;
   logic [NW-1:0]   npix_full;
   logic [TW-1:0]   npix_ff;

   // frame position
   logic [TW-1:0]   t_ff;
   logic [TW-1:0]   t_next;
   logic [TW-1:0]   lag;
   logic [AW-1:0]   wp_ff;
   logic [AW-1:0]   col_ff;
   logic [FH_W-1:0] row_ff;
   logic [WW-1:0]   wp_next;
   logic [WW-1:0]   col_next;
   logic [FH_W:0]   row_next;

   // captured transaction and line memory reads
   logic            cmd_ff;
   pix_type         pix_ff;
   pix_type         rd_mid_ff;
   pix_type         rd_up_ff;
   logic            is_pixel;
   pix_type         new_pix;
   logic            result_due;

   logic [PXW-1:0]  mid_mem [MAX_WIDTH];
   logic [PXW-1:0]  up_mem  [MAX_WIDTH];

   // window: row 0 is two lines back, column 2 is newest
   pix_type         win_ff [3][3];
   logic            row_lo_ff, row_hi_ff, col_lo_ff, col_hi_ff, last_ff;

   // arithmetic stages
   logic [2:0]                         row_ok, col_ok;
   logic [1:0]                         rows_n, cols_n;
   logic [3:0]                         count;
   logic [CHANNELS-1:0][SUM_W-1:0]     sum_acc;
   logic [CHANNELS-1:0][SUM_W-1:0]     sum_ff;
   logic [RECIP_W-1:0]                 recip_ff;
   pix_type                            centre_ff;
   logic [CHANNELS-1:0][PROD_W-1:0]    prod_ff;
   pix_type                            sharp;
   logic [CHANNELS-1:0][PIX_W-1:0]     blur;
   logic [CHANNELS-1:0][PIX_W-1:0]     detail;
   logic [CHANNELS-1:0][PIX_W:0]       sharp_wide;

   // output register
   logic            out_valid_ff;
   pix_type         out_ff;
   logic            out_end_ff;

   // ---------------- configuration ----------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (cmd.csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               width_in = csr_wdata[FW_W-1:0];
               restart  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in = csr_wdata[FH_W-1:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         weff_in = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         weff_in = WW'(MAX_WIDTH);
      end else begin
         weff_in = WW'(width_ff);
      end
      heff_in = (height_ff == '0) ? FH_W'(1) : height_ff;
   end

   assign npix_full = NW'(weff_in) * NW'(heff_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FW_W'(WIDTH_RESET);
         height_ff <= FH_W'(HEIGHT_RESET);
         weff_ff   <= WW'(W_RST);
         heff_ff   <= FH_W'(HEIGHT_RESET);
         npix_ff   <= TW'(NPIX_RST);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         weff_ff   <= weff_in;
         heff_ff   <= heff_in;
         npix_ff   <= TW'(npix_full);
      end
   end

   // ---------------- capture and line memories ----------------
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff    <= req_command;
         pix_ff    <= {req_blue_in, req_green_in, req_red_in};
         rd_mid_ff <= mid_mem[wp_ff];
         rd_up_ff  <= up_mem[wp_ff];
      end
   end

   assign is_pixel   = (cmd_ff == CMD_PIXEL) && (t_ff < npix_ff);
   assign new_pix    = is_pixel ? pix_ff : '0;
   assign lag        = TW'(weff_ff) + TW'(1);
   assign result_due = (t_ff >= lag);

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         mid_mem[wp_ff] <= new_pix;
         up_mem[wp_ff]  <= rd_mid_ff;
      end
   end

   // ---------------- window and border flags ----------------
   assign col_next = WW'(col_ff) + WW'(1);
   assign row_next = {1'b0, row_ff} + (FH_W+1)'(1);
   assign wp_next  = WW'(wp_ff) + WW'(1);
   assign t_next   = t_ff + TW'(1);

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_up_ff;
         win_ff[1][2] <= rd_mid_ff;
         win_ff[2][2] <= new_pix;
         row_lo_ff    <= (row_ff != '0);
         row_hi_ff    <= (row_next < {1'b0, heff_ff});
         col_lo_ff    <= (col_ff != '0);
         col_hi_ff    <= (col_next < weff_ff);
         last_ff      <= (t_ff == npix_ff + TW'(weff_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         t_ff   <= '0;
         wp_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.shift) begin
         if (t_next >= npix_ff + lag) begin
            t_ff   <= '0;
            wp_ff  <= '0;
            col_ff <= '0;
            row_ff <= '0;
         end else begin
            t_ff  <= t_next;
            wp_ff <= (wp_next >= weff_ff) ? '0 : AW'(wp_next);
            if (result_due) begin
               if (col_next >= weff_ff) begin
                  col_ff <= '0;
                  row_ff <= row_next[FH_W-1:0];
               end else begin
                  col_ff <= AW'(col_next);
               end
            end
         end
      end
   end

   // ---------------- masked sum and reciprocal ----------------
   assign row_ok = {row_hi_ff, 1'b1, row_lo_ff};
   assign col_ok = {col_hi_ff, 1'b1, col_lo_ff};
   assign rows_n = 2'd1 + 2'(row_lo_ff) + 2'(row_hi_ff);
   assign cols_n = 2'd1 + 2'(col_lo_ff) + 2'(col_hi_ff);
   assign count  = 4'(rows_n) * 4'(cols_n);

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         sum_acc[k] = '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (row_ok[r] && col_ok[c]) begin
                  sum_acc[k] = sum_acc[k] + SUM_W'(win_ff[r][c][k]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sum_ff    <= sum_acc;
         recip_ff  <= recip(count);
         centre_ff <= win_ff[1][1];
      end
      if (cmd.mul) begin
         for (int k = 0; k < CHANNELS; k++) begin
            prod_ff[k] <= PROD_W'(sum_ff[k]) * PROD_W'(recip_ff);
         end
      end
   end

   // ---------------- sharpen and output register ----------------
   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         blur[k]       = prod_ff[k][RECIP_SHIFT +: PIX_W];
         detail[k]     = (centre_ff[k] > blur[k]) ? (centre_ff[k] - blur[k]) : '0;
         sharp_wide[k] = {1'b0, centre_ff[k]} + {1'b0, detail[k]};
         sharp[k]      = sharp_wide[k][PIX_W] ? PIX_MAX : sharp_wide[k][PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_ff     <= sharp;
         out_end_ff <= last_ff;
      end
   end

   assign status.result_due = result_due;
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];
   assign rsp_frame_end = out_end_ff;

endmodule
